>>> src/sptq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptq_pkg: shared types and constants of the sorted priority task queue
// Holds the command and status codes, the stored entry layout and the
// result record passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package sptq_pkg;

    // Default number of queue slots.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths fixed by the interface.
    localparam int TASK_W   = 8;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Command codes carried on the input tuser bit.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One stored queue entry.
    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // One result record.
    typedef struct packed {
        logic [TASK_W-1:0]  out_task;
        logic [PRIO_W-1:0]  out_priority;
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

endpackage

>>> src/sptq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sptq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/sptq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sptq_seq: queue sequencer
// Walks the entry memory one slot at a time through a single priority
// comparator, shifting entries to open or close a gap, and tracks occupancy.
// ----------------------------------------------------------------------------
module sptq_seq #(
    parameter int QUEUE_DEPTH = sptq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command side
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  logic                          i_cmd,
    input  logic [sptq_pkg::TASK_W-1:0]   i_task_id,
    input  logic [sptq_pkg::PRIO_W-1:0]   i_task_priority,
    // result side
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output sptq_pkg::t_result             o_res
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = $bits(sptq_pkg::t_entry);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EX   = 5'b00100,
        S_PUT  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_occ, n_occ;
    logic [IW-1:0]                 r_idx, n_idx;
    logic                          r_cmd, n_cmd;
    logic [sptq_pkg::TASK_W-1:0]   r_id, n_id;
    logic [sptq_pkg::PRIO_W-1:0]   r_prio, n_prio;
    logic [sptq_pkg::TASK_W-1:0]   r_out_task, n_out_task;
    logic [sptq_pkg::PRIO_W-1:0]   r_out_prio, n_out_prio;
    sptq_pkg::t_status             r_status, n_status;

    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic [EW-1:0]                 ram_wdata;
    logic [EW-1:0]                 ram_rdata;
    sptq_pkg::t_entry              rd_entry;
    sptq_pkg::t_entry              new_entry;
    logic [IW-1:0]                 last_idx;

    sptq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry  = sptq_pkg::t_entry'(ram_rdata);
    assign new_entry = '{task_id: r_id, prio: r_prio};
    assign last_idx  = IW'(r_occ - CW'(1));

    always_comb begin
        n_state    = r_state;
        n_occ      = r_occ;
        n_idx      = r_idx;
        n_cmd      = r_cmd;
        n_id       = r_id;
        n_prio     = r_prio;
        n_out_task = r_out_task;
        n_out_prio = r_out_prio;
        n_status   = r_status;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = EW'(new_entry);

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd      = i_cmd;
                    n_id       = i_task_id;
                    n_prio     = i_task_priority;
                    n_out_task = '0;
                    n_out_prio = '0;
                    n_status   = sptq_pkg::ST_DONE;
                    if (i_cmd == sptq_pkg::CMD_INSERT) begin
                        if (r_occ == CW'(QUEUE_DEPTH)) begin
                            n_status = sptq_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else if (r_occ == '0) begin
                            // Empty queue: the new task becomes the head at once.
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = EW'(sptq_pkg::t_entry'{task_id: i_task_id,
                                                              prio: i_task_priority});
                            n_occ     = CW'(1);
                            n_state   = S_DONE;
                        end else begin
                            n_idx   = last_idx;
                            n_state = S_RD;
                        end
                    end else begin
                        if (r_occ == '0) begin
                            n_status = sptq_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                if (r_cmd == sptq_pkg::CMD_INSERT) begin
                    // Walk from the tail: shift lower priorities up by one slot.
                    ram_we    = 1'b1;
                    ram_waddr = r_idx + IW'(1);
                    if (rd_entry.prio >= r_prio) begin
                        ram_wdata = EW'(new_entry);
                        n_occ     = r_occ + CW'(1);
                        n_state   = S_DONE;
                    end else begin
                        ram_wdata = EW'(rd_entry);
                        if (r_idx == '0) begin
                            n_state = S_PUT;
                        end else begin
                            n_idx   = r_idx - IW'(1);
                            n_state = S_RD;
                        end
                    end
                end else begin
                    // Walk from the head: take slot zero, move the rest down.
                    if (r_idx == '0) begin
                        n_out_task = rd_entry.task_id;
                        n_out_prio = rd_entry.prio;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_idx - IW'(1);
                        ram_wdata = EW'(rd_entry);
                    end
                    if (r_idx == last_idx) begin
                        n_occ   = r_occ - CW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = EW'(new_entry);
                n_occ     = r_occ + CW'(1);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
        r_idx      <= n_idx;
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_prio     <= n_prio;
        r_out_task <= n_out_task;
        r_out_prio <= n_out_prio;
        r_status   <= n_status;
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{out_task:     r_out_task,
                           out_priority: r_out_prio,
                           status:       r_status,
                           entry_count:  sptq_pkg::COUNT_W'(r_occ)};

endmodule

>>> src/sorted_priority_task_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_task_queue_unit: sorted ready queue of prioritised tasks
// Keeps task entries in descending priority order and serves inserts and
// pops over a stream interface, one result per command.
// ----------------------------------------------------------------------------
// Each input transfer is one command: insert a task (tuser low) or pop the
// highest priority task (tuser high). Equal priorities are served first come,
// first served. Every command yields exactly one result transfer carrying the
// popped task and priority (zero unless a pop succeeded), a status (done,
// queue full with the insert rejected, or queue empty) and the occupancy after
// the command, taken modulo 32. Commands are handled one at a time: a single
// comparator walks the entry memory one slot at a time, because every slot
// is read through the registered memory port before it can be compared and
// written back. An insert into an empty queue writes the head directly, and
// a rejected insert or an empty pop goes straight to the result; otherwise
// an insert walks from the tail and a pop from the head. The output register
// holds a finished result, so the next command may be transferred while that
// result still waits to be taken. The entry memory needs no clearing after
// reset, as only occupied slots are ever read.
// ----------------------------------------------------------------------------
module sorted_priority_task_queue_unit #(
    parameter int QUEUE_DEPTH = sptq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] task_id, [15:8] task_priority
    input  logic        i_s_tuser,   // [0] cmd
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] out_task, [15:8] out_priority,
                                     // [20:16] entry_count, [23:21] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    logic              res_valid;
    logic              res_ready;
    sptq_pkg::t_result res;

    // Output register: holds one result until the downstream side takes it.
    logic              r_m_valid;
    sptq_pkg::t_result r_m_res;

    sptq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (i_s_tvalid),
        .o_cmd_ready     (o_s_tready),
        .i_cmd           (i_s_tuser),
        .i_task_id       (i_s_tdata[7:0]),
        .i_task_priority (i_s_tdata[15:8]),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_res           (res)
    );

    // The register may be refilled in the same cycle as it is emptied.
    assign res_ready = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
        if (res_valid && res_ready) begin
            r_m_res <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {3'b000, r_m_res.entry_count, r_m_res.out_priority,
                         r_m_res.out_task};
    assign o_m_tuser  = r_m_res.status;

endmodule
